// ===== rtl/sfu_pkg.sv =====
`timescale 1ns / 1ps
// sfu_pkg: shared types and constants of the spring force unit
// no dependencies; used by spring_force_unit_core

package sfu_pkg;

  localparam int COORD_WIDTH   = 32;   // width of every position and force field
  localparam int FRAC_BITS_DEF = 16;   // default fraction bits (q16.16)
  localparam int PARAM_W       = 31;   // stiffness and rest length width
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;

  localparam logic [PARAM_W-1:0] STIFFNESS_RESET = 31'd65536;
  localparam logic [PARAM_W-1:0] REST_RESET      = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS = 8'd0,
    CFG_REST      = 8'd1,
    CFG_EXT_ONLY  = 8'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] force_x;
    logic signed [COORD_WIDTH-1:0] force_y;
    logic signed [COORD_WIDTH-1:0] force_z;
    logic                          force_applied;
    logic                          saturated;
  } out_t;

endpackage

// ===== rtl/sfu_sqrt.sv =====
`timescale 1ns / 1ps
// sfu_sqrt: pipelined integer square root, one root bit per stage
// standalone; instantiated by spring_force_unit_core

module sfu_sqrt #(
  parameter int SW = 68,
  parameter int TW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SW-1:0]     radicand,
  input  logic [TW-1:0]     in_tag,
  output logic              out_valid,
  output logic [SW/2-1:0]   root,
  output logic [TW-1:0]     out_tag
);

  localparam int RW   = SW / 2;
  localparam int REMW = RW + 2;

  logic            vld [RW];
  logic [REMW-1:0] rem [RW];
  logic [RW-1:0]   q   [RW];
  logic [SW-1:0]   rad [RW];
  logic [TW-1:0]   tag [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic            p_vld;
    logic [REMW-1:0] p_rem;
    logic [RW-1:0]   p_q;
    logic [SW-1:0]   p_rad;
    logic [TW-1:0]   p_tag;
    logic [REMW-1:0] cur;
    logic [REMW-1:0] trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = '0;
      assign p_q   = '0;
      assign p_rad = radicand;
      assign p_tag = in_tag;
    end else begin : g_next
      assign p_vld = vld[i-1];
      assign p_rem = rem[i-1];
      assign p_q   = q[i-1];
      assign p_rad = rad[i-1];
      assign p_tag = tag[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {p_rem[REMW-3:0], p_rad[SW-1:SW-2]};
    assign trial = {p_q, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= p_vld;
      end
      rem[i] <= ge ? (cur - trial) : cur;
      q[i]   <= {p_q[RW-2:0], ge};
      rad[i] <= p_rad << 2;
      tag[i] <= p_tag;
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = q[RW-1];
  assign out_tag   = tag[RW-1];

endmodule

// ===== rtl/sfu_div.sv =====
`timescale 1ns / 1ps
// sfu_div: pipelined restoring divider, several lanes over one divisor
// standalone; instantiated by spring_force_unit_core

module sfu_div #(
  parameter int NW    = 82,
  parameter int DW    = 34,
  parameter int QW    = 33,
  parameter int LANES = 3,
  parameter int TW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [TW-1:0]              in_tag,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quo,
  output logic [LANES-1:0]           ovf,
  output logic [TW-1:0]              out_tag
);

  logic                     vld [QW+1];
  logic [LANES-1:0][DW-1:0] r   [QW+1];
  logic [LANES-1:0][QW-1:0] lo  [QW+1];
  logic [LANES-1:0][QW-1:0] q   [QW+1];
  logic [LANES-1:0]         ov  [QW+1];
  logic [DW-1:0]            d   [QW+1];
  logic [TW-1:0]            tag [QW+1];

  // entry: quotient wider than QW bits is flagged, remainder seeded with the top part
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    for (int l = 0; l < LANES; l++) begin
      ov[0][l] <= (num[l][NW-1:QW] >= den);
      r[0][l]  <= num[l][QW+DW-1:QW];
      lo[0][l] <= num[l][QW-1:0];
      q[0][l]  <= '0;
    end
    d[0]   <= den;
    tag[0] <= in_tag;
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    always_ff @(posedge clk) begin
      logic [DW:0] t;
      logic        ge;
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      for (int l = 0; l < LANES; l++) begin
        t  = {r[j][l], lo[j][l][QW-1]};
        ge = (t >= {1'b0, d[j]});
        r[j+1][l]  <= ge ? DW'(t - {1'b0, d[j]}) : t[DW-1:0];
        lo[j+1][l] <= lo[j][l] << 1;
        q[j+1][l]  <= {q[j][l][QW-2:0], ge};
      end
      ov[j+1]  <= ov[j];
      d[j+1]   <= d[j];
      tag[j+1] <= tag[j];
    end
  end

  assign out_valid = vld[QW];
  assign quo       = q[QW];
  assign ovf       = ov[QW];
  assign out_tag   = tag[QW];

endmodule

// ===== rtl/spring_force_unit_core.sv =====
`timescale 1ns / 1ps
// spring_force_unit_core: pipelined hooke's-law spring force, one item per cycle
// depends on sfu_pkg, sfu_sqrt and sfu_div
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  item     | start, busy, item (sfu_pkg::in_t)        | beat when start && !busy
//  result   | done, result (sfu_pkg::out_t)            | done strobes one cycle, no hold
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| beat when cfg_valid && cfg_ready
//
//  a new item is taken every cycle; busy never rises
//  a 68-bit square root then a 33-bit divide (at the default q16.16); the square-root stages
//  (one bit each) and the divider stages make up most of the pipeline
//  rst (synchronous) clears the valid chain and restores the configuration registers
//  no stalls: the receiver takes each result in the cycle that done is high

module spring_force_unit_core #(
  parameter int FRAC_BITS = sfu_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  sfu_pkg::in_t                    item,
  output logic                            done,
  output sfu_pkg::out_t                   result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int W   = sfu_pkg::COORD_WIDTH;
  localparam int KW  = sfu_pkg::PARAM_W;
  localparam int AW  = W + 1;            // |difference|
  localparam int SW  = 2 * AW + 2;       // sum of squares
  localparam int LW  = SW / 2;           // length
  localparam int PW  = KW + LW;          // stiffness * extension
  localparam int MW  = PW - FRAC_BITS;   // force magnitude
  localparam int MH  = (MW + 1) / 2;     // low half of magnitude for the split multiply
  localparam int NW  = MW + AW;          // dividend
  localparam int QW  = W + 1;            // quotient bits kept before clamping
  localparam int TW  = 3 * AW + 6;
  localparam int DTW = 7;
  localparam int LAT = LW + QW + 9;

  // configuration registers
  logic [KW-1:0] stiffness;
  logic [KW-1:0] rest;
  logic          ext_only;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= sfu_pkg::STIFFNESS_RESET;
      rest      <= sfu_pkg::REST_RESET;
      ext_only  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfu_pkg::CFG_STIFFNESS: stiffness <= cfg_data[KW-1:0];
        sfu_pkg::CFG_REST:      rest      <= cfg_data[KW-1:0];
        sfu_pkg::CFG_EXT_ONLY:  ext_only  <= cfg_data[0];
        default: ;              // unknown index is dropped
      endcase
    end
  end

  // stage 1: differences, magnitude and sign per axis
  logic [2:0][W-1:0]  pos_v;
  logic [2:0][W-1:0]  end_v;
  logic [2:0][AW-1:0] ad_c;
  logic [2:0]         neg_c;
  logic [2:0]         nz_c;

  assign pos_v = {item.pos_z, item.pos_y, item.pos_x};
  assign end_v = {item.end_z, item.end_y, item.end_x};

  always_comb begin
    logic [AW-1:0] dv;
    for (int i = 0; i < 3; i++) begin
      dv       = {pos_v[i][W-1], pos_v[i]} - {end_v[i][W-1], end_v[i]};
      neg_c[i] = dv[AW-1];
      nz_c[i]  = (dv != '0);
      ad_c[i]  = dv[AW-1] ? (~dv + AW'(1)) : dv;
    end
  end

  logic               v1;
  logic [2:0][AW-1:0] ad1;
  logic [2:0]         neg1;
  logic [2:0]         nz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    ad1  <= ad_c;
    neg1 <= neg_c;
    nz1  <= nz_c;
  end

  // stage 2: squares
  logic                 v2;
  logic [2:0][2*AW-1:0] sq2;
  logic [TW-1:0]        tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= ad1[i] * ad1[i];
    end
    tag2 <= {ad1, neg1, nz1};
  end

  // stage 3: sum of squares
  logic          v3;
  logic [SW-1:0] sum3;
  logic [TW-1:0] tag3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sum3 <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
    tag3 <= tag2;
  end

  // length, floor of the square root
  logic          vs;
  logic [LW-1:0] len_s;
  logic [TW-1:0] tag_s;

  sfu_sqrt #(
    .SW (SW),
    .TW (TW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .radicand  (sum3),
    .in_tag    (tag3),
    .out_valid (vs),
    .root      (len_s),
    .out_tag   (tag_s)
  );

  // stage 4: skip decision and extension
  logic          v4;
  logic [LW-1:0] len4;
  logic [LW-1:0] ext4;
  logic          skip4;
  logic [TW-1:0] tag4;
  logic [LW-1:0] rest_l;

  assign rest_l = LW'(rest);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= vs;
    end
    len4  <= len_s;
    ext4  <= (len_s >= rest_l) ? (len_s - rest_l) : (rest_l - len_s);
    // no direction at zero length; bungee slack gives nothing
    skip4 <= (len_s == '0) || (ext_only && (len_s <= rest_l));
    tag4  <= tag_s;
  end

  // stage 5: stiffness times extension
  logic          v5;
  logic [PW-1:0] prod5;
  logic [LW-1:0] len5;
  logic          skip5;
  logic [TW-1:0] tag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    prod5 <= PW'(stiffness) * PW'(ext4);
    len5  <= len4;
    skip5 <= skip4;
    tag5  <= tag4;
  end

  // stage 6: magnitude times |d|, split into two partial products per axis
  logic [MW-1:0]      mag5;
  logic [2:0][AW-1:0] ad5;
  logic [2:0]         neg5;
  logic [2:0]         nz5;

  assign mag5              = prod5[PW-1:FRAC_BITS];
  assign {ad5, neg5, nz5}  = tag5;

  logic                       v6;
  logic [2:0][MH+AW-1:0]      pl6;
  logic [2:0][MW-MH+AW-1:0]   ph6;
  logic [LW-1:0]              len6;
  logic [DTW-1:0]             dtag6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    for (int i = 0; i < 3; i++) begin
      pl6[i] <= (MH+AW)'(mag5[MH-1:0]) * (MH+AW)'(ad5[i]);
      ph6[i] <= (MW-MH+AW)'(mag5[MW-1:MH]) * (MW-MH+AW)'(ad5[i]);
    end
    len6  <= len5;
    dtag6 <= {skip5, neg5, nz5};
  end

  // stage 7: join partial products into the dividend
  logic               v7;
  logic [2:0][NW-1:0] num7;
  logic [LW-1:0]      len7;
  logic [DTW-1:0]     dtag7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    for (int i = 0; i < 3; i++) begin
      num7[i] <= NW'(pl6[i]) + (NW'(ph6[i]) << MH);
    end
    len7  <= len6;
    dtag7 <= dtag6;
  end

  // divide each axis by the length
  logic               vd;
  logic [2:0][QW-1:0] quo_d;
  logic [2:0]         ovf_d;
  logic [DTW-1:0]     dtag_d;

  sfu_div #(
    .NW    (NW),
    .DW    (LW),
    .QW    (QW),
    .LANES (3),
    .TW    (DTW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num       (num7),
    .den       (len7),
    .in_tag    (dtag7),
    .out_valid (vd),
    .quo       (quo_d),
    .ovf       (ovf_d),
    .out_tag   (dtag_d)
  );

  // final stage: sign, clamp and result register
  logic              skip_d;
  logic [2:0]        neg_d;
  logic [2:0]        nz_d;
  logic [2:0][W-1:0] force_c;
  logic [2:0]        sat_c;

  assign {skip_d, neg_d, nz_d} = dtag_d;

  always_comb begin
    logic [QW-1:0] lim_neg;
    logic [QW-1:0] lim_pos;
    logic [QW-1:0] mag;
    lim_neg = QW'(1) << (W - 1);
    lim_pos = lim_neg - QW'(1);
    for (int i = 0; i < 3; i++) begin
      force_c[i] = '0;
      sat_c[i]   = 1'b0;
      mag        = quo_d[i];
      if (!skip_d && nz_d[i]) begin
        if (!neg_d[i]) begin
          // positive difference pulls negative
          if (ovf_d[i] || (quo_d[i] > lim_neg)) begin
            mag      = lim_neg;
            sat_c[i] = 1'b1;
          end
          force_c[i] = W'(~mag + QW'(1));
        end else begin
          if (ovf_d[i] || (quo_d[i] > lim_pos)) begin
            mag      = lim_pos;
            sat_c[i] = 1'b1;
          end
          force_c[i] = mag[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    result.force_x       <= force_c[0];
    result.force_y       <= force_c[1];
    result.force_z       <= force_c[2];
    result.force_applied <= !skip_d;
    result.saturated     <= |sat_c;
  end

  // checks
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("item beat without result at fixed latency");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.force_applied) |->
      (result.force_x == '0 && result.force_y == '0 && result.force_z == '0 &&
       !result.saturated))
    else $error("skipped item carries a force");

  a_sat_applied: assert property (@(posedge clk) disable iff (rst)
    (done && result.saturated) |-> result.force_applied)
    else $error("clamp flagged on a skipped item");

endmodule
